@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Fixed field widths of the request and response channels
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COLOR_W  = 4;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // Control characters
   localparam logic [CHAR_W-1:0] LINE_FEED = 8'h0A;
   localparam logic [CHAR_W-1:0] BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;

   // Request kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_RDWAIT = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_EXEC   = 6'b100000
   } state_type;

   // Commands from the sequencer to the cursor unit
   typedef struct packed {
      logic exec;         // apply the latched character
      logic home_bottom;  // scroll done: cursor to start of bottom row
   } cur_ctl_type;

endpackage

`default_nettype wire

@@ hdl/text_console_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Read request: answered through the RAM read register and the response register;
// no new request is taken until the response is accepted. Write request: applied in
// the EXEC state; when the cursor sits past the last row the screen first scrolls
// (one cell copied per cycle through the RAM port). Reset: synchronous; afterwards a
// clearing pass zeroes the screen RAM, one cell per cycle, with req_ready low.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_kind,
   input  wire logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  wire logic [tcw_pkg::COLOR_W-1:0]     req_fg_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]     req_bg_color,
   input  wire logic                            req_last_of_string,
   input  wire logic [tcw_pkg::INDEX_W-1:0]     req_cell_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [tcw_pkg::CHAR_W-1:0]      rsp_read_char,
   output logic      [tcw_pkg::ATTR_W-1:0]      rsp_read_attr,
   output logic      [tcw_pkg::CURSOR_W-1:0]    rsp_cursor_cell,
   output logic      [tcw_pkg::CURSOR_W-1:0]    rsp_cursor_register
);

   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);

   state_type       state_ff, state_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   logic            cp_valid_ff, cp_valid_in;
   logic [AW-1:0]   cp_addr_ff, cp_addr_in;
   logic            scroll_ff, scroll_in;
   logic            range_ff, range_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic            last_ff, last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;
   logic [CURSOR_W-1:0] rsp_cur_ff, rsp_cur_in;
   logic [CURSOR_W-1:0] rsp_pub_ff, rsp_pub_in;

   cur_ctl_type     cur_ctl;
   logic            cur_full;
   logic            cur_we;
   logic [AW-1:0]   cur_addr;
   logic [CW-1:0]   cursor_nx, pub_nx;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   logic [AW+INDEX_W-1:0]  idx_ext;
   logic [CW+CURSOR_W-1:0] cur_ext, pub_ext;
   logic                   idx_in_range;
   logic                   req_fire;

   // Width adaptation between fixed ports and parameter-sized internals
   assign idx_ext      = {{AW{1'b0}}, req_cell_index};
   assign idx_in_range = (idx_ext < (AW + INDEX_W)'(CELLS));
   assign cur_ext      = {{CURSOR_W{1'b0}}, cursor_nx};
   assign pub_ext      = {{CURSOR_W{1'b0}}, pub_nx};

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock          (clock),
      .reset          (reset),
      .ctl            (cur_ctl),
      .char_code      (char_ff),
      .last_of_string (last_ff),
      .at_end         (cur_full),
      .cell_we        (cur_we),
      .cell_addr      (cur_addr),
      .cursor_nx      (cursor_nx),
      .pub_nx         (pub_nx)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // RAM write port: scroll copy, then clear sweep, then character write
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cur_addr;
      ram_wdata = {attr_ff, (char_ff == BACKSPACE) ? BLANK_CHAR : char_ff};
      if (cp_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = cp_addr_ff;
         ram_wdata = ram_rdata;
      end else if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = cnt_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_EXEC) begin
         ram_we    = cur_we;
      end
   end

   assign ram_raddr = (state_ff == ST_SCROLL) ? cnt_ff : idx_ext[AW-1:0];

   // Cursor unit commands: apply the character, or home after a scroll
   always_comb begin
      cur_ctl             = '0;
      cur_ctl.exec        = (state_ff == ST_EXEC);
      cur_ctl.home_bottom = (state_ff == ST_CLEAR) && scroll_ff && (cnt_ff == AW'(CELLS - 1));
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cp_valid_in  = 1'b0;
      cp_addr_in   = cp_addr_ff;
      scroll_in    = scroll_ff;
      range_in     = range_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_pub_in   = rsp_pub_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_READ) begin
                  range_in = idx_in_range;
                  state_in = ST_RDWAIT;
               end else begin
                  char_in = req_char_code;
                  attr_in = {req_bg_color, req_fg_color};
                  last_in = req_last_of_string;
                  if (cur_full) begin
                     cnt_in   = AW'(COLUMNS);
                     state_in = ST_SCROLL;
                  end else begin
                     state_in = ST_EXEC;
                  end
               end
            end
         end
         ST_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = range_ff ? ram_rdata[CHAR_W-1:0] : '0;
            rsp_attr_in  = range_ff ? ram_rdata[CELL_W-1:CHAR_W] : '0;
            rsp_cur_in   = cur_ext[CURSOR_W-1:0];
            rsp_pub_in   = pub_ext[CURSOR_W-1:0];
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // read row below, write it one row up in the following cycle
            cp_valid_in = 1'b1;
            cp_addr_in  = cnt_ff - AW'(COLUMNS);
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            cnt_in    = AW'(CELLS - COLUMNS);
            scroll_in = 1'b1;
            state_in  = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (cnt_ff == AW'(CELLS - 1)) begin
               if (scroll_ff) begin
                  scroll_in = 1'b0;
                  state_in  = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = '0;
            rsp_attr_in  = '0;
            rsp_cur_in   = cur_ext[CURSOR_W-1:0];
            rsp_pub_in   = pub_ext[CURSOR_W-1:0];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         cp_valid_ff  <= 1'b0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cp_valid_ff  <= cp_valid_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cp_addr_ff  <= cp_addr_in;
      range_ff    <= range_in;
      char_ff     <= char_in;
      attr_ff     <= attr_in;
      last_ff     <= last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_cur_ff  <= rsp_cur_in;
      rsp_pub_ff  <= rsp_pub_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_char       = rsp_char_ff;
   assign rsp_read_attr       = rsp_attr_ff;
   assign rsp_cursor_cell     = rsp_cur_ff;
   assign rsp_cursor_register = rsp_pub_ff;

`ifndef ASSERT_OFF
   // Copy writes only while the scroll pipeline runs
   a_copy_in_scroll: assert property (@(posedge clock) disable iff (reset)
      cp_valid_ff |-> (state_ff == ST_SCROLL) || (state_ff == ST_DRAIN))
      else $error("scroll copy write outside scroll");

   // A write with the cursor past the last row must scroll first
   a_full_scrolls: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == KIND_WRITE) && cur_full |=> (state_ff == ST_SCROLL))
      else $error("write at end of screen did not scroll");

   // Characters are only applied with the cursor inside the screen
   a_exec_in_screen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !cur_full)
      else $error("character applied past last row");

   // A response appears only from a finished read or write
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC) || $past(state_ff == ST_RDWAIT))
      else $error("response raised from wrong state");

   // Cursor never runs beyond one past the last cell
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_nx <= CW'(CELLS))
      else $error("cursor out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/tcw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/tcw_cursor.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tcw_pkg::cur_ctl_type                   ctl,
   input  wire logic [tcw_pkg::CHAR_W-1:0]             char_code,
   input  wire logic                                   last_of_string,
   output logic                                        at_end,
   output logic                                        cell_we,
   output logic [$clog2(ROWS*COLUMNS)-1:0]             cell_addr,
   output logic [$clog2(ROWS*COLUMNS+1)-1:0]           cursor_nx,
   output logic [$clog2(ROWS*COLUMNS+1)-1:0]           pub_nx
);

   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int XW    = $clog2(COLUMNS);

   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] pub_ff, pub_in;
   logic [XW-1:0] col_ff, col_in;   // always cursor mod COLUMNS
   logic [CW-1:0] cur_inc, cur_dec, cur_lf;

   assign cur_inc = cursor_ff + CW'(1);
   assign cur_dec = cursor_ff - CW'(1);
   assign cur_lf  = cursor_ff - CW'(col_ff) + CW'(COLUMNS);
   assign at_end  = (cursor_ff == CW'(CELLS));

   // Next cursor, column and cell write for one character, or home after a scroll
   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      cell_we   = 1'b0;
      cell_addr = cursor_ff[AW-1:0];
      if (ctl.home_bottom) begin
         cursor_in = CW'(CELLS - COLUMNS);
         col_in    = '0;
      end else if (ctl.exec) begin
         if (char_code == LINE_FEED) begin
            cursor_in = cur_lf;
            col_in    = '0;
         end else if (char_code == BACKSPACE) begin
            if (cursor_ff != '0) begin
               cursor_in = cur_dec;
               col_in    = (col_ff == '0) ? XW'(COLUMNS - 1) : col_ff - XW'(1);
               cell_we   = 1'b1;
               cell_addr = cur_dec[AW-1:0];
            end
         end else begin
            cursor_in = cur_inc;
            col_in    = (col_ff == XW'(COLUMNS - 1)) ? '0 : col_ff + XW'(1);
            cell_we   = 1'b1;
         end
      end
      pub_in = (ctl.exec && last_of_string) ? cursor_in : pub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         col_ff    <= '0;
         pub_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         pub_ff    <= pub_in;
      end
   end

   assign cursor_nx = cursor_in;
   assign pub_nx    = pub_in;

endmodule

`default_nettype wire
